@@ hdl/fdd_pkg.sv @@
// Package for the forward difference derivative block: widths, constants and types.
// Used by the channel interfaces, every module of the block and the checker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fdd_pkg;

  localparam int SampleBits = 24;
  localparam int WinDepth   = 6;
  localparam int CntBits    = 3;
  localparam int RegBits    = 24;
  localparam int ResBits    = 32;
  localparam int CfgIdxBits = 1;
  localparam int FracBits   = 16;

  localparam logic [CfgIdxBits-1:0] RegInvStep   = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegInvStepSq = 1'b1;

  localparam logic [RegBits-1:0] InvStepRst   = 24'd32768;
  localparam logic [RegBits-1:0] InvStepSqRst = 24'd16384;

  localparam int QueueDepth = 2;
  localparam int QPtrBits   = 1;

  // Pipeline widths of the back end.
  localparam int NumStages = 6;
  localparam int DiffBits  = SampleBits + WinDepth - 1;
  localparam int MagBits   = SampleBits + 9;
  localparam int NumBits   = MagBits + 1;
  localparam int ProdBits  = MagBits + RegBits;
  localparam int XBits     = ProdBits - FracBits + 1;
  localparam int YBits     = XBits - 2;
  localparam int Y1Bits    = 35;
  localparam int Y2Bits    = 33;
  localparam int YWBits    = Y1Bits;
  localparam int YExtBits  = (YBits > YWBits + 1) ? YBits : YWBits + 1;
  localparam int LowBits   = 18;
  localparam int RecipBits = 32;
  localparam int QEstBits  = 32;
  localparam int PlBits    = LowBits + RecipBits;
  localparam int PhBits    = YWBits - LowBits + RecipBits;
  localparam int SumBits   = YWBits + RecipBits;
  localparam int DqBits    = QEstBits + 4;

  // Rounding offsets after the Q.16 shift, and the remaining divisors (60/4, 12/4).
  localparam int Round1 = 30;
  localparam int Round2 = 6;
  localparam int Div1   = 15;
  localparam int Div2   = 3;
  localparam logic [RecipBits-1:0] Recip1 = 32'h8888_8888;
  localparam logic [RecipBits-1:0] Recip2 = 32'hAAAA_AAAA;
  localparam int Shift1 = 35;
  localparam int Shift2 = 33;

  localparam logic [ResBits:0] SatMagNeg = (ResBits + 1)'(1) << (ResBits - 1);
  localparam logic [ResBits:0] SatMagPos = SatMagNeg - (ResBits + 1)'(1);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [WinDepth-1:0][SampleBits-1:0] window_t;

  typedef struct packed {
    window_t            win;
    logic [CntBits-1:0] avail;
    logic               last;
  } job_t;

  typedef struct packed {
    logic [RegBits-1:0] inv_step;
    logic [RegBits-1:0] inv_step_sq;
  } scale_t;

  typedef enum logic [0:0] {
    FrRun,
    FrFlush
  } front_state_e;

endpackage

`default_nettype wire

@@ hdl/fdd_if.sv @@
// Channel interfaces of the derivative block: sample input and result output.
// Depends on fdd_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface fdd_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [fdd_pkg::SampleBits-1:0] sample;
  logic                    last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface fdd_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [fdd_pkg::ResBits-1:0] first_derivative;
  logic signed [fdd_pkg::ResBits-1:0] second_derivative;
  logic                 last_result;

  modport source (output valid, first_derivative, second_derivative, last_result,
                  input ready);
  modport sink (input valid, first_derivative, second_derivative, last_result,
                output ready);
endinterface

`default_nettype wire

@@ hdl/forward_difference_derivatives.sv @@
// Top level of the forward difference derivative block: configuration registers,
// front end, job queue and arithmetic back end. Depends on fdd_pkg, fdd_if,
// fdd_front, fdd_queue and fdd_back.
//
//   channel   direction  handshake            payload
//   samp_i    in         valid/ready          sample, last_sample
//   res_o     out        valid/ready          first_derivative, second_derivative, last_result
//   cfg       in         cfg_we_i, no ready   cfg_idx_i, cfg_wdata_i
//
// One sample per cycle is taken while the queue has room, as the window fills and runs;
// once it is full each sample gives one result. After an item with last_sample the input holds
// ready low while the flush sequencer queues one job per pending position (one to five).
// A result passes the back stages to the output register, one per cycle while not stalled.
// Reset clears the control state and loads the reciprocal registers; a stalled output
// stalls the whole back pipeline, and the front keeps taking items until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module forward_difference_derivatives (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fdd_in_if.sink                           samp_i,
  fdd_out_if.source                        res_o,
  input  logic                             cfg_we_i,
  input  logic [fdd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [fdd_pkg::RegBits-1:0]      cfg_wdata_i
);

  fdd_pkg::scale_t scale_q;
  logic            push, full, q_valid, q_pop;
  fdd_pkg::job_t   push_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q.inv_step    <= fdd_pkg::InvStepRst;
      scale_q.inv_step_sq <= fdd_pkg::InvStepSqRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdd_pkg::RegInvStep:   scale_q.inv_step    <= cfg_wdata_i;
        fdd_pkg::RegInvStepSq: scale_q.inv_step_sq <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  fdd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  fdd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (q_pop)
  );

  fdd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .q_pop_o   (q_pop),
    .scale_i   (scale_q),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

@@ hdl/fdd_front.sv @@
// Front end: takes samples, keeps the six-sample window and the fill count,
// and queues one job per result, including the flush after the last sample. Uses fdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  fdd_in_if.sink        samp_i,
  input  logic          full_i,
  output logic          push_o,
  output fdd_pkg::job_t job_o
);

  fdd_pkg::front_state_e           state_q, state_d;
  logic [fdd_pkg::CntBits-1:0]     cnt_q, cnt_d;
  fdd_pkg::window_t                win_q, win_d, win_in;
  logic                            acc;

  function automatic fdd_pkg::window_t shift_win(input fdd_pkg::window_t w);
    shift_win = w >> fdd_pkg::SampleBits;
  endfunction

  assign samp_i.ready = (state_q == fdd_pkg::FrRun) && !full_i;
  assign acc          = samp_i.valid && samp_i.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    win_d       = win_q;
    push_o      = 1'b0;
    job_o.win   = win_q;
    job_o.avail = cnt_q;
    job_o.last  = 1'b0;
    win_in      = win_q;
    win_in[cnt_q] = samp_i.sample;
    case (state_q)
      fdd_pkg::FrRun: begin
        if (acc) begin
          if (cnt_q == fdd_pkg::CntBits'(fdd_pkg::WinDepth - 1)) begin
            push_o      = 1'b1;
            job_o.win   = win_in;
            job_o.avail = fdd_pkg::CntBits'(fdd_pkg::WinDepth);
            win_d       = shift_win(win_in);
          end else begin
            win_d = win_in;
            cnt_d = cnt_q + fdd_pkg::CntBits'(1);
          end
          if (samp_i.last_sample) begin
            state_d = fdd_pkg::FrFlush;
          end
        end
      end
      fdd_pkg::FrFlush: begin
        if (!full_i) begin
          push_o     = 1'b1;
          job_o.last = (cnt_q == fdd_pkg::CntBits'(1));
          win_d      = shift_win(win_q);
          cnt_d      = cnt_q - fdd_pkg::CntBits'(1);
          if (cnt_q == fdd_pkg::CntBits'(1)) begin
            state_d = fdd_pkg::FrRun;
          end
        end
      end
      default: begin
        state_d = fdd_pkg::FrRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdd_pkg::FrRun;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

`default_nettype wire

@@ hdl/fdd_queue.sv @@
// Two-entry job queue between the front end and the arithmetic back end.
// Depends on fdd_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module fdd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fdd_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output fdd_pkg::job_t job_o,
  input  logic          pop_i
);

  fdd_pkg::job_t                 mem_q [fdd_pkg::QueueDepth];
  logic [fdd_pkg::QPtrBits-1:0]  wp_q, rp_q;
  logic [fdd_pkg::QPtrBits:0]    cnt_q;
  logic                          do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (fdd_pkg::QPtrBits + 1)'(fdd_pkg::QueueDepth));
  assign job_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + fdd_pkg::QPtrBits'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + fdd_pkg::QPtrBits'(1);
      end
      cnt_q <= cnt_q + {{fdd_pkg::QPtrBits{1'b0}}, do_push}
                     - {{fdd_pkg::QPtrBits{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fdd_back.sv @@
// Back end: six-stage pipeline from a window job to the rounded, saturated derivatives,
// plus the output register. Two lanes run side by side, first and second derivative.
// Depends on fdd_pkg and the fdd_out_if interface.
`timescale 1ns / 1ps
`default_nettype none

module fdd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  fdd_pkg::job_t   q_job_i,
  output logic            q_pop_o,
  input  fdd_pkg::scale_t scale_i,
  fdd_out_if.source       res_o
);

  localparam int NS = fdd_pkg::NumStages;

  logic                                  en;
  logic [NS-1:0]                         vld_q;
  logic [NS-1:0]                         last_q;
  logic [1:0]                            neg_q [2:NS];
  logic                                  out_valid_q;
  logic signed [fdd_pkg::ResBits-1:0]    first_q, second_q;
  logic                                  out_last_q;

  logic signed [fdd_pkg::DiffBits-1:0]   t [fdd_pkg::WinDepth];
  logic signed [fdd_pkg::DiffBits-1:0]   d_d [1:fdd_pkg::WinDepth-1];
  logic signed [fdd_pkg::DiffBits-1:0]   d_q [1:fdd_pkg::WinDepth-1];

  logic signed [fdd_pkg::NumBits-1:0]    dx [1:fdd_pkg::WinDepth-1];
  logic signed [fdd_pkg::NumBits-1:0]    num [2];
  logic [fdd_pkg::MagBits-1:0]           mag_d [2];
  logic [fdd_pkg::MagBits-1:0]           mag_q [2];
  logic [1:0]                            neg_d;

  logic [fdd_pkg::ProdBits-1:0]          p_d [2];
  logic [fdd_pkg::ProdBits-1:0]          p_q [2];

  logic [fdd_pkg::XBits-1:0]             x [2];
  logic [fdd_pkg::YExtBits-1:0]          yext [2];
  logic [fdd_pkg::YWBits-1:0]            y4_d [2];
  logic [fdd_pkg::YWBits-1:0]            y4_q [2];

  logic [fdd_pkg::PlBits-1:0]            pl_d [2];
  logic [fdd_pkg::PlBits-1:0]            pl_q [2];
  logic [fdd_pkg::PhBits-1:0]            ph_d [2];
  logic [fdd_pkg::PhBits-1:0]            ph_q [2];
  logic [fdd_pkg::YWBits-1:0]            y5_q [2];

  logic [fdd_pkg::SumBits-1:0]           sum [2];
  logic [fdd_pkg::QEstBits-1:0]          qe_d [2];
  logic [fdd_pkg::QEstBits-1:0]          qe_q [2];
  logic [fdd_pkg::YWBits-1:0]            y6_q [2];

  logic [fdd_pkg::DqBits-1:0]            dq [2];
  logic [fdd_pkg::DqBits:0]              rem [2];
  logic [fdd_pkg::ResBits:0]             quo [2];
  logic [fdd_pkg::ResBits:0]             quo_s [2];
  logic [fdd_pkg::ResBits-1:0]           res_d [2];

  assign en      = !out_valid_q || res_o.ready;
  assign q_pop_o = en;

  // Stage 1: forward differences of the window, orders beyond the available samples as zero.
  always_comb begin
    for (int i = 0; i < fdd_pkg::WinDepth; i++) begin
      t[i] = fdd_pkg::DiffBits'($signed(q_job_i.win[i]));
    end
    for (int k = 1; k < fdd_pkg::WinDepth; k++) begin
      for (int i = 0; i < fdd_pkg::WinDepth - 1; i++) begin
        if (i + k < fdd_pkg::WinDepth) begin
          t[i] = t[i + 1] - t[i];
        end
      end
      d_d[k] = ((k + 1) <= int'(q_job_i.avail)) ? t[0] : '0;
    end
  end

  // Stage 2: weighted sums over the common denominators 60 and 12, split into sign and size.
  always_comb begin
    for (int k = 1; k < fdd_pkg::WinDepth; k++) begin
      dx[k] = fdd_pkg::NumBits'(d_q[k]);
    end
    num[0] = dx[1] * fdd_pkg::NumBits'(60) - dx[2] * fdd_pkg::NumBits'(30)
           + dx[3] * fdd_pkg::NumBits'(20) - dx[4] * fdd_pkg::NumBits'(15)
           + dx[5] * fdd_pkg::NumBits'(12);
    num[1] = dx[2] * fdd_pkg::NumBits'(12) - dx[3] * fdd_pkg::NumBits'(12)
           + dx[4] * fdd_pkg::NumBits'(11) - dx[5] * fdd_pkg::NumBits'(10);
    for (int l = 0; l < 2; l++) begin
      neg_d[l] = num[l][fdd_pkg::NumBits-1];
      mag_d[l] = neg_d[l] ? fdd_pkg::MagBits'(-num[l]) : fdd_pkg::MagBits'(num[l]);
    end
  end

  // Stages 3 to 6: scale, round, clamp, and divide by 15 or 3 through a reciprocal.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_d[l] = fdd_pkg::ProdBits'(mag_q[l])
             * fdd_pkg::ProdBits'((l == 0) ? scale_i.inv_step : scale_i.inv_step_sq);

      x[l] = fdd_pkg::XBits'(p_q[l] >> fdd_pkg::FracBits)
           + fdd_pkg::XBits'((l == 0) ? fdd_pkg::Round1 : fdd_pkg::Round2);
      yext[l] = fdd_pkg::YExtBits'(x[l] >> 2);
      if ((yext[l] >> ((l == 0) ? fdd_pkg::Y1Bits : fdd_pkg::Y2Bits)) != '0) begin
        y4_d[l] = (fdd_pkg::YWBits'(1) << ((l == 0) ? fdd_pkg::Y1Bits : fdd_pkg::Y2Bits))
                - fdd_pkg::YWBits'(1);
      end else begin
        y4_d[l] = fdd_pkg::YWBits'(yext[l]);
      end

      pl_d[l] = fdd_pkg::PlBits'(y4_q[l][fdd_pkg::LowBits-1:0])
              * fdd_pkg::PlBits'((l == 0) ? fdd_pkg::Recip1 : fdd_pkg::Recip2);
      ph_d[l] = fdd_pkg::PhBits'(y4_q[l][fdd_pkg::YWBits-1:fdd_pkg::LowBits])
              * fdd_pkg::PhBits'((l == 0) ? fdd_pkg::Recip1 : fdd_pkg::Recip2);

      sum[l]  = (fdd_pkg::SumBits'(ph_q[l]) << fdd_pkg::LowBits) + fdd_pkg::SumBits'(pl_q[l]);
      qe_d[l] = fdd_pkg::QEstBits'(sum[l] >> ((l == 0) ? fdd_pkg::Shift1 : fdd_pkg::Shift2));

      // The estimate is at most one low; the remainder tells.
      dq[l]  = fdd_pkg::DqBits'(qe_q[l])
             * fdd_pkg::DqBits'((l == 0) ? fdd_pkg::Div1 : fdd_pkg::Div2);
      rem[l] = (fdd_pkg::DqBits + 1)'(y6_q[l]) - (fdd_pkg::DqBits + 1)'(dq[l]);
      quo[l] = (fdd_pkg::ResBits + 1)'(qe_q[l])
             + (fdd_pkg::ResBits + 1)'(rem[l] >= (fdd_pkg::DqBits + 1)'((l == 0) ?
                                                 fdd_pkg::Div1 : fdd_pkg::Div2));
      if (neg_q[NS][l]) begin
        quo_s[l] = (quo[l] > fdd_pkg::SatMagNeg) ? fdd_pkg::SatMagNeg : quo[l];
        res_d[l] = fdd_pkg::ResBits'(0) - fdd_pkg::ResBits'(quo_s[l]);
      end else begin
        quo_s[l] = (quo[l] > fdd_pkg::SatMagPos) ? fdd_pkg::SatMagPos : quo[l];
        res_d[l] = fdd_pkg::ResBits'(quo_s[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NS-2:0], q_valid_i};
      out_valid_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q    <= {last_q[NS-2:0], q_job_i.last};
      d_q       <= d_d;
      neg_q[2]  <= neg_d;
      for (int s = 3; s <= NS; s++) begin
        neg_q[s] <= neg_q[s - 1];
      end
      mag_q     <= mag_d;
      p_q       <= p_d;
      y4_q      <= y4_d;
      pl_q      <= pl_d;
      ph_q      <= ph_d;
      y5_q      <= y4_q;
      qe_q      <= qe_d;
      y6_q      <= y5_q;
      first_q   <= res_d[0];
      second_q  <= res_d[1];
      out_last_q <= last_q[NS-1];
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.first_derivative  = first_q;
  assign res_o.second_derivative = second_q;
  assign res_o.last_result       = out_last_q;

endmodule

`default_nettype wire

@@ hdl/fdd_checker.sv @@
// Port-level checker for the forward difference derivative block, bound to its top level.
// Depends on fdd_pkg and on the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module fdd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_last_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [fdd_pkg::ResBits-1:0] out_first_i,
  input logic signed [fdd_pkg::ResBits-1:0] out_second_i,
  input logic                              out_last_i
);

  logic       in_acc, out_acc;
  logic [3:0] pend_q;
  logic       seen_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Sequences closed at the input whose final result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {3'b000, in_acc && in_last_i} - {3'b000, out_acc && out_last_i};
      if (in_acc) begin
        seen_q <= 1'b1;
      end
    end
  end

  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> !in_ready_i)
    else $error("input taken in the cycle after a final sample");

  a_last_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_i |-> pend_q != 4'd0)
    else $error("final result without a pending final sample");

  a_no_result_before_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("result offered before any sample was taken");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_first_i)
      && $stable(out_second_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind forward_difference_derivatives fdd_checker u_fdd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (samp_i.valid),
  .in_ready_i   (samp_i.ready),
  .in_last_i    (samp_i.last_sample),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_first_i  (res_o.first_derivative),
  .out_second_i (res_o.second_derivative),
  .out_last_i   (res_o.last_result)
);

`default_nettype wire

@@ sim/forward_difference_derivatives_tb.sv @@
// Self-checking testbench for forward_difference_derivatives: drives sample sequences,
// predicts first and second derivative results and compares every result item.
// Depends on fdd_pkg, fdd_if and the block's RTL.
`timescale 1ns / 1ps

module forward_difference_derivatives_tb;
  import fdd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 150;
  localparam longint SampleMax = 64'sd8388607;
  localparam longint SampleMin = -64'sd8388608;

  typedef enum int {
    SeqRandom,
    SeqSmooth,
    SeqExtreme
  } seq_kind_e;

  typedef struct {
    logic signed [ResBits-1:0] first;
    logic signed [ResBits-1:0] second;
    logic                      last;
  } deriv_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [RegBits-1:0] cfg_wdata_i;

  fdd_in_if  samp_if ();
  fdd_out_if res_if ();

  forward_difference_derivatives dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .samp_i      (samp_if.sink),
    .res_o       (res_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  longint       deriv_window [WinDepth];
  int           deriv_fill;
  logic [RegBits-1:0] scale_first;
  logic [RegBits-1:0] scale_second;
  deriv_t       pending_derivs [$];

  int  err_count;
  int  items_sent;
  int  results_seen;
  int  cycle_count;
  int  idle_pct;
  int  stall_pct;
  bit  hold_req;
  logic hold_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_derivs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  // Rounds num * scale / den to nearest, halves away from zero, and saturates.
  function automatic logic signed [ResBits-1:0] round_scaled(longint num,
                                                             logic [RegBits-1:0] scale,
                                                             longint unsigned den);
    bit neg;
    longint unsigned mag;
    longint unsigned sc;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned res;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    sc  = {40'd0, scale};
    quo = mag / den;
    rem = mag % den;
    res = quo * sc + (rem * sc + den / 2) / den;
    if (neg) begin
      if (res > 64'h8000_0000) res = 64'h8000_0000;
      res = 64'd0 - res;
    end else if (res > 64'h7FFF_FFFF) begin
      res = 64'h7FFF_FFFF;
    end
    return res[ResBits-1:0];
  endfunction

  function automatic deriv_t derivs_at(int base, int avail, bit last);
    longint t [WinDepth];
    longint d [WinDepth];
    longint n1;
    longint n2;
    deriv_t r;
    for (int i = 0; i < WinDepth; i++) begin
      t[i] = (base + i < WinDepth) ? deriv_window[base + i] : 0;
      d[i] = 0;
    end
    for (int k = 1; k < WinDepth; k++) begin
      for (int i = 0; i + k < WinDepth; i++) t[i] = t[i + 1] - t[i];
      d[k] = (k + 1 <= avail) ? t[0] : 0;
    end
    n1 = 60 * d[1] - 30 * d[2] + 20 * d[3] - 15 * d[4] + 12 * d[5];
    n2 = 12 * d[2] - 12 * d[3] + 11 * d[4] - 10 * d[5];
    r.first  = round_scaled(n1, scale_first, 64'd60 << FracBits);
    r.second = round_scaled(n2, scale_second, 64'd12 << FracBits);
    r.last   = last;
    return r;
  endfunction

  function automatic void predict_sample(sample_t s, bit last);
    if (deriv_fill >= WinDepth) deriv_fill = WinDepth - 1;
    deriv_window[deriv_fill] = longint'(s);
    deriv_fill++;
    if (deriv_fill == WinDepth) begin
      pending_derivs.push_back(derivs_at(0, WinDepth, 1'b0));
      for (int i = 0; i + 1 < WinDepth; i++) deriv_window[i] = deriv_window[i + 1];
      deriv_window[WinDepth - 1] = 0;
      deriv_fill = WinDepth - 1;
    end
    if (last) begin
      for (int i = 0; i < deriv_fill; i++) begin
        pending_derivs.push_back(derivs_at(i, deriv_fill - i, i + 1 == deriv_fill));
      end
      for (int i = 0; i < WinDepth; i++) deriv_window[i] = 0;
      deriv_fill = 0;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    deriv_t exp_d;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_derivs.size() == 0) begin
        report_error($sformatf("unexpected result: first %0d second %0d last %0b",
                               res_if.first_derivative, res_if.second_derivative,
                               res_if.last_result));
      end else begin
        exp_d = pending_derivs.pop_front();
        if (res_if.first_derivative !== exp_d.first)
          report_error($sformatf("result %0d first_derivative: got %0d, expected %0d",
                                 results_seen, res_if.first_derivative, exp_d.first));
        if (res_if.second_derivative !== exp_d.second)
          report_error($sformatf("result %0d second_derivative: got %0d, expected %0d",
                                 results_seen, res_if.second_derivative, exp_d.second));
        if (res_if.last_result !== exp_d.last)
          report_error($sformatf("result %0d last_result: got %0b, expected %0b",
                                 results_seen, res_if.last_result, exp_d.last));
      end
    end
    if (!rst_ni || hold_on) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off, started on request by the pressure test.
  initial begin
    hold_on = 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on <= 1'b0;
      hold_req = 1'b0;
    end
  end

  task automatic send_sample(sample_t s, bit last);
    while ($urandom_range(99) < idle_pct) begin
      samp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    samp_if.valid       <= 1'b1;
    samp_if.sample      <= s;
    samp_if.last_sample <= last;
    @(posedge clk_i);
    while (!samp_if.ready) @(posedge clk_i);
    predict_sample(s, last);
    items_sent++;
  endtask

  task automatic send_sequence(int len, seq_kind_e kind);
    longint a0;
    longint a1;
    longint a2;
    longint v;
    bit     hi;
    a0 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    a1 = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
    a2 = longint'($urandom_range(0, 1 << 11)) - (1 << 10);
    hi = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      case (kind)
        SeqSmooth: begin
          v = a0 + a1 * i + a2 * i * i;
          if (v > SampleMax) v = SampleMax;
          if (v < SampleMin) v = SampleMin;
        end
        SeqExtreme: begin
          v  = hi ? SampleMax : SampleMin;
          hi = !hi;
        end
        default: begin
          v = longint'(sample_t'($urandom()));
        end
      endcase
      send_sample(sample_t'(v), i == len - 1);
    end
  endtask

  task automatic wait_drain();
    samp_if.valid <= 1'b0;
    while (pending_derivs.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_scales(logic [RegBits-1:0] inv, logic [RegBits-1:0] inv_sq);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegInvStep;
    cfg_wdata_i <= inv;
    @(posedge clk_i);
    cfg_idx_i   <= RegInvStepSq;
    cfg_wdata_i <= inv_sq;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scale_first  = inv;
    scale_second = inv_sq;
    @(posedge clk_i);
  endtask

  // Every flush length from a lone sample up to a full window, at the reset scales.
  task automatic test_flush_lengths();
    idle_pct  = 0;
    stall_pct = 0;
    for (int len = 1; len <= WinDepth; len++) send_sequence(len, SeqExtreme);
    wait_drain();
  endtask

  task automatic test_scale_extremes();
    write_scales('1, '1);
    send_sequence(7, SeqExtreme);
    wait_drain();
    write_scales('0, '0);
    send_sequence(5, SeqRandom);
    wait_drain();
  endtask

  task automatic test_random_traffic(int idle, int stall, logic [RegBits-1:0] inv,
                                     logic [RegBits-1:0] inv_sq, int count);
    int sent;
    int len;
    int pick;
    seq_kind_e kind;
    idle_pct  = idle;
    stall_pct = stall;
    write_scales(inv, inv_sq);
    sent = 0;
    while (sent < count) begin
      len  = ($urandom_range(99) < 25) ? $urandom_range(1, WinDepth)
                                       : $urandom_range(WinDepth + 1, 24);
      pick = $urandom_range(99);
      kind = (pick < 50) ? SeqSmooth : (pick < 90) ? SeqRandom : SeqExtreme;
      send_sequence(len, kind);
      sent += len;
    end
    wait_drain();
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_scales(InvStepRst, InvStepSqRst);
    hold_req = 1'b1;
    send_sequence(14, SeqSmooth);
    send_sequence(13, SeqRandom);
    send_sequence(13, SeqSmooth);
    wait_drain();
  endtask

  initial begin
    rst_ni              = 1'b0;
    samp_if.valid       = 1'b0;
    samp_if.sample      = '0;
    samp_if.last_sample = 1'b0;
    res_if.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = RegInvStep;
    cfg_wdata_i         = '0;
    hold_req            = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    err_count           = 0;
    items_sent          = 0;
    results_seen        = 0;
    cycle_count         = 0;
    deriv_fill          = 0;
    scale_first         = InvStepRst;
    scale_second        = InvStepSqRst;
    for (int i = 0; i < WinDepth; i++) deriv_window[i] = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flush_lengths();
    test_scale_extremes();
    test_random_traffic(0, 0, '1, '1, 85);
    test_random_traffic(72, 0, '0, '1, 85);
    test_random_traffic(0, 72, 24'd65536, 24'd65536, 85);
    test_random_traffic(26, 26, RegBits'($urandom()), RegBits'($urandom()), 85);
    test_backpressure();

    $display("Covered %0d sample items and %0d results: flush lengths, scale extremes,",
             items_sent, results_seen);
    $display("four idle and stall mixes and a long output hold-off; %0d errors.", err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
